// ----- design/palette_match_with_row_flip_assert.svh -----
// Assertion macros for the palette matcher with row flip.
// Included by the top level; depends on nothing else.
`ifndef PALETTE_MATCH_WITH_ROW_FLIP_ASSERT_SVH
`define PALETTE_MATCH_WITH_ROW_FLIP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PMRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmrf: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PMRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmrf: next-cycle check failed");

`endif

// ----- design/pmrf_pkg.sv -----
// Shared types, constants and palette functions for the palette matcher.
// No dependencies; imported by palette_match_with_row_flip.
`default_nettype none

package pmrf_pkg;

    localparam int MAX_SIDE     = 4096;
    localparam int PALETTE_SIZE = 16;

    localparam int CHAN_W    = 8;
    localparam int SIDE_W    = 13;
    localparam int COUNT_W   = $clog2(MAX_SIDE);
    localparam int ADDR_W    = 24;
    localparam int INDEX_W   = 8;
    localparam int PAL_IDX_W = $clog2(PALETTE_SIZE);
    localparam int PAL_LEAVES = 2 ** PAL_IDX_W;
    localparam int DIST_W    = CHAN_W + 2;

    localparam logic [CHAN_W-1:0]  DARK_LEVEL = 8'h7F;
    localparam logic [CHAN_W-1:0]  FULL_LEVEL = 8'hFF;
    localparam logic [INDEX_W-1:0] NO_INK     = 8'hFF;

    typedef logic [CHAN_W-1:0]    t_chan;
    typedef logic [DIST_W-1:0]    t_dist;
    typedef logic [PAL_IDX_W-1:0] t_pal_idx;
    typedef logic [SIDE_W-1:0]    t_side;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [ADDR_W-1:0]    t_addr;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_channel;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Fixed palette: black, dark blue, dark green, dark red, then blacks, white last.
    function automatic t_chan palette_rgb(input t_pal_idx n, input t_channel ch);
        t_chan v;
        v = '0;
        if (n == t_pal_idx'(PALETTE_SIZE - 1)) begin
            v = FULL_LEVEL;
        end else if (n == t_pal_idx'(1) && ch == CH_BLUE) begin
            v = DARK_LEVEL;
        end else if (n == t_pal_idx'(2) && ch == CH_GREEN) begin
            v = DARK_LEVEL;
        end else if (n == t_pal_idx'(3) && ch == CH_RED) begin
            v = DARK_LEVEL;
        end
        return v;
    endfunction

    function automatic t_dist abs_diff(input t_chan a, input t_chan b);
        return (a > b) ? t_dist'(a - b) : t_dist'(b - a);
    endfunction

    // Zero is taken as one, anything above the largest side is clamped.
    function automatic t_side eff_side(input t_side v);
        t_side r;
        if (v == '0) begin
            r = t_side'(1);
        end else if (v > t_side'(MAX_SIDE)) begin
            r = t_side'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/palette_match_with_row_flip.sv -----
// Top level of the palette matcher with vertically flipped addresses.
// Depends on pmrf_pkg and on palette_match_with_row_flip_assert.svh.
//
// Usage: RGB pixels enter on the s_axis channel in raster order, bottom row
// first, red in tdata[7:0], green in [15:8], blue in [23:16]. Each pixel
// leaves on the m_axis channel with its palette index in tdata[7:0] (255 when
// white is nearest, meaning no ink), its top-row-first buffer address in
// tdata[31:8], and tlast high on the final pixel of the picture.
// Picture size is set through the write port (index 0 width, index 1 height);
// any write restarts the picture at its first pixel. Write only while idle.
// A result passes through the capture stage and then the result register
// before it is shown; a stall at the output can hold it in the capture stage.
// Throughput is one pixel per clock: a capture stage holds the pixel and its
// address, a result register holds the matched index, and the two stages
// collapse bubbles, so a new pixel is still taken while a result waits as
// long as the capture stage is free. When the receiver stalls, results hold
// and the input stalls once both stages are full.
// Synchronous active-low reset empties both stages and sets the picture to
// 1 x 1 pixels with counters at zero.

`default_nettype none

`include "palette_match_with_row_flip_assert.svh"

module palette_match_with_row_flip
    import pmrf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Pixel input: [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [23:0]       i_s_axis_tdata,
    // Result output: [7:0] color_index, [31:8] dest_address
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [31:0]            o_m_axis_tdata,
    output logic                   o_m_axis_tlast,
    // Configuration writes
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_index,
    input  wire logic [SIDE_W-1:0] i_cfg_data
);

    // Picture geometry and scan position.
    t_side  r_width;
    t_side  r_height;
    t_addr  r_start_base;
    t_addr  r_row_base;
    t_count r_col;
    t_count r_row;

    // Capture stage.
    logic   r_s1_valid;
    t_chan  r_s1_red;
    t_chan  r_s1_green;
    t_chan  r_s1_blue;
    t_addr  r_s1_addr;
    logic   r_s1_last;

    // Result stage.
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    t_addr              r_out_addr;
    logic               r_out_last;

    logic  in_acc;
    logic  s1_adv;
    logic  last_col;
    logic  last_row;
    t_side n_width;
    t_side n_height;
    logic [2*SIDE_W-1:0] start_prod;
    t_pal_idx best_idx;
    logic [INDEX_W-1:0] n_index;

    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign last_col = (t_side'(r_col) + t_side'(1)) >= r_width;
    assign last_row = (t_side'(r_row) + t_side'(1)) >= r_height;

    // New geometry on a configuration write; the base of the first row is
    // the product (height - 1) * width, cut to the address width.
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        unique case (i_cfg_index)
            CFG_IMAGE_WIDTH:  n_width  = eff_side(i_cfg_data);
            CFG_IMAGE_HEIGHT: n_height = eff_side(i_cfg_data);
        endcase
        start_prod = (n_height - t_side'(1)) * n_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= t_side'(1);
            r_height     <= t_side'(1);
            r_start_base <= '0;
            r_row_base   <= '0;
            r_col        <= '0;
            r_row        <= '0;
        end else if (i_cfg_wr_en) begin
            r_width      <= n_width;
            r_height     <= n_height;
            r_start_base <= start_prod[ADDR_W-1:0];
            r_row_base   <= start_prod[ADDR_W-1:0];
            r_col        <= '0;
            r_row        <= '0;
        end else if (in_acc) begin
            if (!last_col) begin
                r_col <= r_col + t_count'(1);
            end else if (!last_row) begin
                // Rows arrive bottom first, so each new row sits one row higher.
                r_col      <= '0;
                r_row      <= r_row + t_count'(1);
                r_row_base <= r_row_base - t_addr'(r_width);
            end else begin
                r_col      <= '0;
                r_row      <= '0;
                r_row_base <= r_start_base;
            end
        end
    end

    // Capture stage: the pixel plus its address and end-of-picture flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_red   <= i_s_axis_tdata[7:0];
            r_s1_green <= i_s_axis_tdata[15:8];
            r_s1_blue  <= i_s_axis_tdata[23:16];
            r_s1_addr  <= r_row_base + t_addr'(r_col);
            r_s1_last  <= last_col && last_row;
        end
    end

    // All palette distances in parallel, then a pairwise minimum tree. At each
    // node the left (lower index) side keeps a tie. Padding leaves carry the
    // largest distance and never win.
    always_comb begin
        t_dist    lvl_d [PAL_IDX_W+1][PAL_LEAVES];
        t_pal_idx lvl_i [PAL_IDX_W+1][PAL_LEAVES];
        for (int n = 0; n < PAL_LEAVES; n++) begin
            lvl_i[0][n] = t_pal_idx'(n);
            if (n < PALETTE_SIZE) begin
                lvl_d[0][n] =
                    abs_diff(r_s1_red,   palette_rgb(t_pal_idx'(n), CH_RED))
                  + abs_diff(r_s1_green, palette_rgb(t_pal_idx'(n), CH_GREEN))
                  + abs_diff(r_s1_blue,  palette_rgb(t_pal_idx'(n), CH_BLUE));
            end else begin
                lvl_d[0][n] = '1;
            end
        end
        for (int l = 0; l < PAL_IDX_W; l++) begin
            for (int k = 0; k < PAL_LEAVES; k++) begin
                lvl_d[l+1][k] = lvl_d[l][k];
                lvl_i[l+1][k] = lvl_i[l][k];
            end
            for (int k = 0; k < (PAL_LEAVES >> (l + 1)); k++) begin
                if (lvl_d[l][2*k+1] < lvl_d[l][2*k]) begin
                    lvl_d[l+1][k] = lvl_d[l][2*k+1];
                    lvl_i[l+1][k] = lvl_i[l][2*k+1];
                end else begin
                    lvl_d[l+1][k] = lvl_d[l][2*k];
                    lvl_i[l+1][k] = lvl_i[l][2*k];
                end
            end
        end
        best_idx = lvl_i[PAL_IDX_W][0];
        n_index  = (best_idx == t_pal_idx'(PALETTE_SIZE - 1)) ?
                   NO_INK : INDEX_W'(best_idx);
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_index <= n_index;
            r_out_addr  <= r_s1_addr;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_addr, r_out_index};
    assign o_m_axis_tlast  = r_out_last;

    // The last pixel of a picture is the end of the top row, whose flipped
    // address is width - 1.
    `PMRF_ASSERT_IMPL(a_last_addr, i_clk, i_rst_n,
        r_out_valid && r_out_last, r_out_addr == t_addr'(r_width) - t_addr'(1))
    // The scan position never leaves the picture.
    `PMRF_ASSERT_IMPL(a_pos_bound, i_clk, i_rst_n, 1'b1,
        (t_side'(r_col) < r_width) && (t_side'(r_row) < r_height))
    // Both stages full under a stall: the input must be held off.
    `PMRF_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !i_m_axis_tready, !o_s_axis_tready)
    // A captured pixel that is passed on shows up as a result next cycle.
    `PMRF_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n,
        r_s1_valid && s1_adv, r_out_valid)

endmodule

`default_nettype wire
